### rtl/scts_pkg.sv
// Shared constants for the sorted codepoint table search block.
// Field widths, transaction kind codes, register indexes and reset values.
// No dependencies.
package scts_pkg;

    localparam int MAX_ENTRIES_DEF = 4096;
    localparam int TIER_COUNT_DEF  = 2;

    localparam int KIND_W   = 2;
    localparam int INDEX_W  = 12;
    localparam int CP_W     = 21;
    localparam int COUNT_W  = 13;
    localparam int SIDE_W   = 7;
    localparam int SQ_W     = 13;
    localparam int OFFSET_W = 26;

    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EITHER = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIG_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_SIDE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIG_SIDE    = 2'd3;

    localparam logic [CP_W-1:0]   CP_LIMIT         = 21'h10FFFF;
    localparam logic [SIDE_W-1:0] SIDE_MAX         = 7'd64;
    localparam logic [SIDE_W-1:0] SMALL_SIDE_RESET = 7'd20;
    localparam logic [SIDE_W-1:0] BIG_SIDE_RESET   = 7'd32;

endpackage

### rtl/sorted_codepoint_table_search_top.sv
// Top level of the sorted codepoint table search block: table memory,
// binary-search sequencer, offset multiply and output register.
// Depends on scts_pkg.
//
//  channel  | dir | handshake                 | payload
//  ---------+-----+---------------------------+--------------------------------
//  s_*      | in  | s_tvalid / s_tready       | tuser kind, tier; tdata index, cp
//  m_*      | out | m_tvalid / m_tready       | tdata found, tier, index, offset
//  cfg_*    | in  | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// A write transaction is done in the cycle it is accepted. A lookup takes its accepting
// cycle, a setup state (START) per tier, a table read (PROBE) and a compare (CMP) per
// probe, at most ceil(log2(count+1)) probes per tier, the offset multiply states MUL1,
// MUL2 and MUL3 on a hit, and the result load (DONE). An either-tier lookup may search
// both tiers. s_tready is low from acceptance of a lookup until its result is
// loaded; a held result stalls only that final load. No clearing pass.
module sorted_codepoint_table_search_top #(
    parameter int MAX_ENTRIES = scts_pkg::MAX_ENTRIES_DEF,
    parameter int TIER_COUNT  = scts_pkg::TIER_COUNT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [11:0] entry_index, [32:12] codepoint, [39:33] zero
    input  logic [scts_pkg::IN_DATA_W-1:0]    s_tdata,
    // [1:0] kind, [2] tier
    input  logic [scts_pkg::IN_USER_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] found, [1] hit_tier, [13:2] hit_index, [39:14] pixel_offset
    output logic [scts_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [scts_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [scts_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int TIERS_BUILT = (TIER_COUNT > 2) ? 2 : TIER_COUNT;
    localparam int MEM_DEPTH   = TIERS_BUILT * MAX_ENTRIES;
    localparam int AW          = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int IW          = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW          = $clog2(MAX_ENTRIES + 1);
    localparam int PW          = IW + scts_pkg::SQ_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_PROBE = 3'd2;
    localparam logic [2:0] ST_CMP   = 3'd3;
    localparam logic [2:0] ST_MUL1  = 3'd4;
    localparam logic [2:0] ST_MUL2  = 3'd5;
    localparam logic [2:0] ST_MUL3  = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    logic [2:0]                        state_reg, state_next;
    logic                              tier_reg, tier_next;
    logic                              either_reg, either_next;
    logic [scts_pkg::CP_W-1:0]         cp_reg, cp_next;
    logic [CW-1:0]                     lo_reg, lo_next;
    logic [CW-1:0]                     hi_reg, hi_next;
    logic [IW-1:0]                     mid_reg, mid_next;
    logic                              found_reg, found_next;
    logic [scts_pkg::SQ_W-1:0]         sq_reg, sq_next;
    logic [scts_pkg::OFFSET_W-1:0]     prod_reg, prod_next;
    logic                              m_tvalid_reg, m_tvalid_next;
    logic [scts_pkg::OUT_DATA_W-1:0]   m_tdata_reg, m_tdata_next;

    logic [scts_pkg::COUNT_W-1:0]      small_count_reg, big_count_reg;
    logic [scts_pkg::SIDE_W-1:0]       small_side_reg, big_side_reg;

    logic [scts_pkg::CP_W-1:0]         mem [MEM_DEPTH];
    logic [scts_pkg::CP_W-1:0]         rd_data_reg;
    logic [AW-1:0]                     rd_addr, wr_addr;
    logic                              wr_en;

    logic [scts_pkg::KIND_W-1:0]       in_kind;
    logic                              in_tier;
    logic [scts_pkg::INDEX_W-1:0]      in_index;
    logic [scts_pkg::CP_W-1:0]         in_cp;

    logic [scts_pkg::COUNT_W-1:0]      count_sel;
    logic [CW-1:0]                     count_clamp;
    logic [scts_pkg::SIDE_W-1:0]       side_sel, side_clamp;
    logic [CW:0]                       mid_sum;
    logic [IW-1:0]                     mid_calc;
    logic [CW-1:0]                     lo_cand, hi_cand;
    logic                              tier_ok, in_tier_ok, in_index_ok;

    function automatic logic [AW-1:0] tier_base(input logic t);
        tier_base = t ? AW'(MAX_ENTRIES) : '0;
    endfunction

    assign in_kind  = s_tuser[1:0];
    assign in_tier  = s_tuser[2];
    assign in_index = s_tdata[11:0];
    assign in_cp    = s_tdata[32:12];

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign count_sel   = tier_reg ? big_count_reg : small_count_reg;
    assign count_clamp = (32'(count_sel) > MAX_ENTRIES) ? CW'(MAX_ENTRIES) : CW'(count_sel);
    assign side_sel    = tier_reg ? big_side_reg : small_side_reg;
    assign side_clamp  = (side_sel > scts_pkg::SIDE_MAX) ? scts_pkg::SIDE_MAX : side_sel;
    assign mid_sum     = {1'b0, lo_reg} + {1'b0, hi_reg} - (CW+1)'(1);
    assign mid_calc    = IW'(mid_sum[CW:1]);
    assign tier_ok     = (32'(tier_reg) < TIERS_BUILT);
    assign in_tier_ok  = (32'(in_tier) < TIERS_BUILT);
    assign in_index_ok = (32'(in_index) < MAX_ENTRIES);
    assign wr_addr     = tier_base(in_tier) + AW'(in_index);
    assign rd_addr     = tier_base(tier_reg) + AW'(mid_calc);

    always_comb
    begin
        state_next    = state_reg;
        tier_next     = tier_reg;
        either_next   = either_reg;
        cp_next       = cp_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        found_next    = found_reg;
        sq_next       = sq_reg;
        prod_next     = prod_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        wr_en         = 1'b0;
        lo_cand       = lo_reg;
        hi_cand       = hi_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (in_kind)
                        scts_pkg::KIND_WRITE:
                        begin
                            wr_en = in_tier_ok && in_index_ok;
                        end
                        scts_pkg::KIND_LOOKUP:
                        begin
                            tier_next   = in_tier;
                            either_next = 1'b0;
                            cp_next     = in_cp;
                            state_next  = ST_START;
                        end
                        scts_pkg::KIND_EITHER:
                        begin
                            tier_next   = 1'b0;
                            either_next = 1'b1;
                            cp_next     = in_cp;
                            state_next  = ST_START;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_START:
            begin
                lo_next    = '0;
                hi_next    = count_clamp;
                found_next = 1'b0;
                if (!tier_ok || (cp_reg > scts_pkg::CP_LIMIT) || (count_clamp == '0))
                begin
                    if (either_reg && !tier_reg)
                    begin
                        tier_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                mid_next   = mid_calc;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (rd_data_reg == cp_reg)
                begin
                    found_next = 1'b1;
                    state_next = ST_MUL1;
                end
                else
                begin
                    if (rd_data_reg < cp_reg)
                    begin
                        lo_cand = CW'(mid_reg) + CW'(1);
                    end
                    else
                    begin
                        hi_cand = CW'(mid_reg);
                    end
                    lo_next = lo_cand;
                    hi_next = hi_cand;
                    if (lo_cand < hi_cand)
                    begin
                        state_next = ST_PROBE;
                    end
                    else if (either_reg && !tier_reg)
                    begin
                        tier_next  = 1'b1;
                        state_next = ST_START;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_MUL1:
            begin
                sq_next    = scts_pkg::SQ_W'(side_clamp) * scts_pkg::SQ_W'(side_clamp);
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                prod_next  = scts_pkg::OFFSET_W'(PW'(mid_reg) * PW'(sq_reg));
                state_next = ST_MUL3;
            end
            ST_MUL3:
            begin
                prod_next  = prod_reg + {prod_reg[scts_pkg::OFFSET_W-2:0], 1'b0};
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    if (found_reg)
                    begin
                        m_tdata_next = {prod_reg, scts_pkg::INDEX_W'(mid_reg), tier_reg, 1'b1};
                    end
                    else
                    begin
                        m_tdata_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= in_cp;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            either_reg      <= 1'b0;
            tier_reg        <= 1'b0;
            found_reg       <= 1'b0;
            lo_reg          <= '0;
            hi_reg          <= '0;
            m_tvalid_reg    <= 1'b0;
            small_count_reg <= '0;
            big_count_reg   <= '0;
            small_side_reg  <= scts_pkg::SMALL_SIDE_RESET;
            big_side_reg    <= scts_pkg::BIG_SIDE_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            either_reg   <= either_next;
            tier_reg     <= tier_next;
            found_reg    <= found_next;
            lo_reg       <= lo_next;
            hi_reg       <= hi_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    scts_pkg::CFG_SMALL_COUNT: small_count_reg <= cfg_data;
                    scts_pkg::CFG_BIG_COUNT:   big_count_reg   <= cfg_data;
                    scts_pkg::CFG_SMALL_SIDE:
                        small_side_reg <= cfg_data[scts_pkg::SIDE_W-1:0];
                    scts_pkg::CFG_BIG_SIDE:
                        big_side_reg <= cfg_data[scts_pkg::SIDE_W-1:0];
                    default: small_count_reg <= small_count_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cp_reg      <= cp_next;
        mid_reg     <= mid_next;
        sq_reg      <= sq_next;
        prod_reg    <= prod_next;
        m_tdata_reg <= m_tdata_next;
    end

    a_probe_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE) |-> (lo_reg < hi_reg))
        else $error("probe issued on an empty search window");

    a_mid_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |-> ((CW'(mid_reg) >= lo_reg) && (CW'(mid_reg) < hi_reg)))
        else $error("probe position outside the search window");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata == '0))
        else $error("miss transaction carries nonzero fields");

    a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && ((s_tuser[1:0] == scts_pkg::KIND_LOOKUP) ||
                                  (s_tuser[1:0] == scts_pkg::KIND_EITHER)))
        |=> !s_tready)
        else $error("ready during a lookup");

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for sorted_codepoint_table_search_top: loads both tiers with
// sorted codepoints, runs lookups under several register settings and random idling.
// Depends on scts_pkg and the block's RTL.
module tb_top;

    localparam logic [scts_pkg::KIND_W-1:0] KIND_NONE = 2'd3;
    localparam int SETTLE_CYCLES = 100;
    localparam int CYCLE_LIMIT   = 500_000;
    localparam int RUN_PHASES    = 8;
    localparam int PHASE_ITEMS   = 100;
    localparam int LOAD_ENTRIES  = 192;

    typedef struct packed {
        logic [scts_pkg::KIND_W-1:0]  kind;
        logic                         tier;
        logic [scts_pkg::INDEX_W-1:0] entry_index;
        logic [scts_pkg::CP_W-1:0]    codepoint;
    } glyph_req_t;

    typedef struct packed {
        logic                          found;
        logic                          hit_tier;
        logic [scts_pkg::INDEX_W-1:0]  hit_index;
        logic [scts_pkg::OFFSET_W-1:0] pixel_offset;
    } glyph_hit_t;

    typedef struct packed {
        logic [scts_pkg::CFG_IDX_W-1:0]  index;
        logic [scts_pkg::CFG_DATA_W-1:0] data;
    } reg_write_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [scts_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic [scts_pkg::IN_USER_W-1:0]  s_tuser = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [scts_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [scts_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [scts_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    glyph_req_t glyph_reqs [$];
    glyph_hit_t lookup_results_due [$];
    reg_write_t reg_writes [$];

    logic [scts_pkg::CP_W-1:0] cp_store [0:1][0:scts_pkg::MAX_ENTRIES_DEF-1];
    logic [scts_pkg::CP_W-1:0] cp_plan  [0:1][0:scts_pkg::MAX_ENTRIES_DEF-1];
    int small_count_q, big_count_q, small_side_q, big_side_q;
    int plan_small, plan_big;

    int queued_count = 0;
    int sent_count = 0;
    int reg_queued = 0;
    int reg_done = 0;
    int fail_count = 0;
    int cycle_count = 0;

    glyph_req_t send_item;
    int  send_wait = 0;
    int  recv_wait = 0;
    bit  send_calm = 1'b0;
    bit  recv_calm = 1'b0;

    sorted_codepoint_table_search_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int draw_gap(input bit calm);
        return calm ? 0 : int'($urandom_range(0, 10));
    endfunction

    function automatic logic search_tier(input logic t, input logic [scts_pkg::CP_W-1:0] cp,
                                         output logic [scts_pkg::INDEX_W-1:0] pos);
        int lo;
        int hi;
        int mid;
        pos = '0;
        lo = 0;
        hi = t ? big_count_q : small_count_q;
        if (hi > scts_pkg::MAX_ENTRIES_DEF)
            hi = scts_pkg::MAX_ENTRIES_DEF;
        if (cp > scts_pkg::CP_LIMIT)
            return 1'b0;
        while (lo < hi)
        begin
            mid = (lo + hi - 1) >> 1;
            if (cp_store[t][mid] == cp)
            begin
                pos = scts_pkg::INDEX_W'(mid);
                return 1'b1;
            end
            if (cp_store[t][mid] < cp)
                lo = mid + 1;
            else
                hi = mid;
        end
        return 1'b0;
    endfunction

    function automatic void predict_lookup(input glyph_req_t r);
        glyph_hit_t res;
        logic [scts_pkg::INDEX_W-1:0] pos;
        logic hit;
        int side;
        res = '0;
        case (r.kind)
            scts_pkg::KIND_WRITE:
            begin
                cp_store[r.tier][r.entry_index] = r.codepoint;
                return;
            end
            scts_pkg::KIND_LOOKUP:
            begin
                hit = search_tier(r.tier, r.codepoint, pos);
                res.hit_tier = r.tier;
            end
            scts_pkg::KIND_EITHER:
            begin
                hit = search_tier(1'b0, r.codepoint, pos);
                res.hit_tier = 1'b0;
                if (!hit)
                begin
                    hit = search_tier(1'b1, r.codepoint, pos);
                    res.hit_tier = 1'b1;
                end
            end
            default:
                return;
        endcase
        if (hit)
        begin
            side = res.hit_tier ? big_side_q : small_side_q;
            if (side > int'(scts_pkg::SIDE_MAX))
                side = int'(scts_pkg::SIDE_MAX);
            res.found        = 1'b1;
            res.hit_index    = pos;
            res.pixel_offset = scts_pkg::OFFSET_W'(int'(pos) * side * side * 3);
        end
        else
        begin
            res = '0;
        end
        lookup_results_due.push_back(res);
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] want,
                                   input logic [63:0] got);
        $display("[%0t] mismatch on %s: expected %0h, got %0h", $realtime, field, want, got);
        fail_count++;
    endtask

    task automatic check_result(input logic [scts_pkg::OUT_DATA_W-1:0] d);
        glyph_hit_t want;
        if (lookup_results_due.size() == 0)
        begin
            report_mismatch("unexpected result", '0, 64'(d));
            return;
        end
        want = lookup_results_due.pop_front();
        if (d[0] !== want.found)
            report_mismatch("found", 64'(want.found), 64'(d[0]));
        if (d[1] !== want.hit_tier)
            report_mismatch("hit_tier", 64'(want.hit_tier), 64'(d[1]));
        if (d[13:2] !== want.hit_index)
            report_mismatch("hit_index", 64'(want.hit_index), 64'(d[13:2]));
        if (d[39:14] !== want.pixel_offset)
            report_mismatch("pixel_offset", 64'(want.pixel_offset), 64'(d[39:14]));
    endtask

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_lookup(send_item);
                sent_count++;
                if ($urandom_range(0, 63) == 0)
                    send_calm = !send_calm;
                send_wait = draw_gap(send_calm);
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    s_tvalid <= 1'b0;
                end
                else if (glyph_reqs.size() > 0)
                begin
                    send_item = glyph_reqs.pop_front();
                    s_tvalid  <= 1'b1;
                    s_tdata   <= {7'b0, send_item.codepoint, send_item.entry_index};
                    s_tuser   <= {send_item.tier, send_item.kind};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor; hold each result for its drawn stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                check_result(m_tdata);
                if ($urandom_range(0, 63) == 0)
                    recv_calm = !recv_calm;
                recv_wait = draw_gap(recv_calm);
            end
            if (recv_wait > 0)
            begin
                if (m_tvalid)
                    recv_wait--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // register write driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_valid     <= 1'b0;
            cfg_index     <= '0;
            cfg_data      <= '0;
            small_count_q = 0;
            big_count_q   = 0;
            small_side_q  = int'(scts_pkg::SMALL_SIDE_RESET);
            big_side_q    = int'(scts_pkg::BIG_SIDE_RESET);
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    scts_pkg::CFG_SMALL_COUNT: small_count_q = int'(cfg_data);
                    scts_pkg::CFG_BIG_COUNT:   big_count_q   = int'(cfg_data);
                    scts_pkg::CFG_SMALL_SIDE:
                        small_side_q = int'(cfg_data[scts_pkg::SIDE_W-1:0]);
                    scts_pkg::CFG_BIG_SIDE:
                        big_side_q = int'(cfg_data[scts_pkg::SIDE_W-1:0]);
                    default: ;
                endcase
                reg_done++;
            end
            if (!(cfg_valid && !cfg_ready))
            begin
                if (reg_writes.size() > 0)
                begin
                    reg_write_t w;
                    w = reg_writes.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_index <= w.index;
                    cfg_data  <= w.data;
                end
                else
                begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic queue_req(input logic [scts_pkg::KIND_W-1:0] kind, input logic tier,
                             input logic [scts_pkg::INDEX_W-1:0] idx,
                             input logic [scts_pkg::CP_W-1:0] cp);
        glyph_req_t r;
        r.kind        = kind;
        r.tier        = tier;
        r.entry_index = idx;
        r.codepoint   = cp;
        if (kind == scts_pkg::KIND_WRITE)
            cp_plan[tier][idx] = cp;
        glyph_reqs.push_back(r);
        queued_count++;
    endtask

    task automatic queue_reg(input logic [scts_pkg::CFG_IDX_W-1:0] idx, input int value);
        reg_write_t w;
        w.index = idx;
        w.data  = scts_pkg::CFG_DATA_W'(value);
        reg_writes.push_back(w);
        reg_queued++;
    endtask

    task automatic settle();
        while (sent_count != queued_count || lookup_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input int sc, input int bc, input int ss, input int bs);
        queue_reg(scts_pkg::CFG_SMALL_COUNT, sc);
        queue_reg(scts_pkg::CFG_BIG_COUNT, bc);
        queue_reg(scts_pkg::CFG_SMALL_SIDE, ss);
        queue_reg(scts_pkg::CFG_BIG_SIDE, bs);
        plan_small = (sc > scts_pkg::MAX_ENTRIES_DEF) ? scts_pkg::MAX_ENTRIES_DEF : sc;
        plan_big   = (bc > scts_pkg::MAX_ENTRIES_DEF) ? scts_pkg::MAX_ENTRIES_DEF : bc;
        while (reg_done != reg_queued)
            @(posedge clk);
    endtask

    // counts may reach past the loaded entries only when every lookup is beyond Unicode
    task automatic random_items(input int n, input bit wild);
        int done;
        int roll;
        int c;
        int idx;
        logic t;
        logic [scts_pkg::KIND_W-1:0] k;
        logic [scts_pkg::CP_W-1:0] lo_cp;
        logic [scts_pkg::CP_W-1:0] hi_cp;
        done = 0;
        while (done < n)
        begin
            roll = int'($urandom_range(0, 99));
            if (wild && roll < 80)
                roll = 77;
            t    = 1'($urandom_range(0, 1));
            k    = $urandom_range(0, 1) ? scts_pkg::KIND_EITHER : scts_pkg::KIND_LOOKUP;
            idx  = int'($urandom_range(0, LOAD_ENTRIES - 1));
            if (roll < 60)
            begin
                c = t ? plan_big : plan_small;
                if (c > 0)
                begin
                    if ($urandom_range(0, 9) == 0)
                        idx = $urandom_range(0, 1) ? c - 1 : 0;
                    else
                        idx = int'($urandom_range(0, c - 1));
                end
                queue_req(k, t, scts_pkg::INDEX_W'($urandom), cp_plan[t][idx]);
            end
            else if (roll < 75)
            begin
                queue_req(k, t, scts_pkg::INDEX_W'($urandom),
                          scts_pkg::CP_W'($urandom_range(0, scts_pkg::CP_LIMIT)));
            end
            else if (roll < 80)
            begin
                queue_req(k, t, scts_pkg::INDEX_W'($urandom),
                          scts_pkg::CP_W'($urandom_range(scts_pkg::CP_LIMIT + 1, 21'h1FFFFF)));
            end
            else if (roll < 95)
            begin
                // keep the tier sorted around the rewritten entry
                lo_cp = (idx == 0) ? '0 : cp_plan[t][idx - 1];
                hi_cp = (idx == LOAD_ENTRIES - 1) ? scts_pkg::CP_LIMIT : cp_plan[t][idx + 1];
                queue_req(scts_pkg::KIND_WRITE, t, scts_pkg::INDEX_W'(idx),
                          scts_pkg::CP_W'($urandom_range(hi_cp, lo_cp)));
            end
            else if (roll < 97)
            begin
                queue_req(scts_pkg::KIND_WRITE, t, scts_pkg::INDEX_W'($urandom),
                          scts_pkg::CP_W'($urandom));
            end
            else
            begin
                queue_req(KIND_NONE, t, scts_pkg::INDEX_W'($urandom), scts_pkg::CP_W'($urandom));
            end
            if (roll < 97)
                done++;
        end
    endtask

    initial
    begin
        int p;
        int i;
        int v;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // empty tiers after reset
        queue_req(scts_pkg::KIND_LOOKUP, 1'b0, '0, '0);
        queue_req(scts_pkg::KIND_LOOKUP, 1'b1, '1, scts_pkg::CP_LIMIT);
        queue_req(scts_pkg::KIND_EITHER, 1'b0, '0, 21'h1FFFFF);
        queue_req(KIND_NONE, 1'b1, '1, 21'h1FFFFF);
        queue_req(KIND_NONE, 1'b0, '0, '0);
        queue_req(scts_pkg::KIND_WRITE, 1'b0, '1, 21'h1FFFFF);

        // load the low entries of both tiers with ascending codepoints
        for (int t = 0; t < 2; t++)
        begin
            v = (t == 0) ? 0 : 'h100;
            for (i = 0; i < LOAD_ENTRIES; i++)
            begin
                if (t == 1 && i == LOAD_ENTRIES - 1)
                    v = int'(scts_pkg::CP_LIMIT);
                queue_req(scts_pkg::KIND_WRITE, t[0], scts_pkg::INDEX_W'(i),
                          scts_pkg::CP_W'(v));
                v = v + int'($urandom_range(0, 4000));
                if (v > int'(scts_pkg::CP_LIMIT))
                    v = int'(scts_pkg::CP_LIMIT);
            end
        end

        for (p = 0; p < RUN_PHASES; p++)
        begin
            settle();
            case (p)
                0: configure(LOAD_ENTRIES, LOAD_ENTRIES, 64, 64);
                1: configure(LOAD_ENTRIES, LOAD_ENTRIES - 1, 127, 65);
                2: configure(8191, 4097, 20, 32);
                3: configure(1, 1, 1, 1);
                4: configure(0, LOAD_ENTRIES, 0, 20);
                5: configure(LOAD_ENTRIES, 0, 33, 0);
                default: configure(int'($urandom_range(0, LOAD_ENTRIES)),
                                   int'($urandom_range(0, LOAD_ENTRIES)),
                                   int'($urandom_range(0, 127)), int'($urandom_range(0, 127)));
            endcase
            if (p == 0)
            begin
                queue_req(scts_pkg::KIND_LOOKUP, 1'b0, '0, cp_plan[0][0]);
                queue_req(scts_pkg::KIND_LOOKUP, 1'b1, '0, cp_plan[1][LOAD_ENTRIES - 1]);
                queue_req(scts_pkg::KIND_EITHER, 1'b1, '1, cp_plan[1][0]);
                queue_req(scts_pkg::KIND_EITHER, 1'b0, '0, cp_plan[0][LOAD_ENTRIES - 1]);
                queue_req(scts_pkg::KIND_LOOKUP, 1'b0, '0,
                          scts_pkg::CP_W'(scts_pkg::CP_LIMIT + 1));
            end
            random_items(PHASE_ITEMS, p == 2);
        end

        settle();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
